[hw/rtl/msrt_pkg.sv]
// ----------------------------------------------------------------------------
// msrt_pkg - shared constants and types of the merge sorter
// Data width, default set size, sequencer state codes and the control bundle
// from the sequencer to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msrt_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    // sequencer states
    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_MSTART = 3'd1;
    localparam logic [2:0] S_MERGE  = 3'd2;
    localparam logic [2:0] S_OSTART = 3'd3;
    localparam logic [2:0] S_OLOAD  = 3'd4;
    localparam logic [2:0] S_OWAIT  = 3'd5;

    typedef struct packed {
        logic wr0_en;     // write bank 0
        logic wr1_en;     // write bank 1
        logic wr_sel_in;  // write data from the input item, else merge winner
        logic rd_sel;     // bank that holds the current source run
        logic take_left;  // merge winner is the left run head
        logic out_load;   // capture read data into the output register
        logic out_last;   // captured value is the final one of the set
    } t_seq_ctrl;

endpackage

`default_nettype wire

[hw/rtl/msrt_ram.sv]
// ----------------------------------------------------------------------------
// msrt_ram - element bank
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module msrt_ram #(
    parameter int DEPTH = msrt_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [msrt_pkg::DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]               i_raddr_a,
    input  wire logic [AW-1:0]               i_raddr_b,
    output logic      [msrt_pkg::DATA_W-1:0] o_rdata_a,
    output logic      [msrt_pkg::DATA_W-1:0] o_rdata_b
);

    logic [msrt_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

[hw/rtl/msrt_seq.sv]
// ----------------------------------------------------------------------------
// msrt_seq - load, merge-pass and readout sequencer
// Counts the set in, runs bottom-up merge passes between the banks writing one
// element per cycle save at run-pair starts, then walks the sorted bank out.
// ----------------------------------------------------------------------------
`default_nettype none

module msrt_seq #(
    parameter int CAPACITY = msrt_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_last,
    input  wire logic                               i_out_take,
    input  wire logic signed [msrt_pkg::DATA_W-1:0] i_src_a,
    input  wire logic signed [msrt_pkg::DATA_W-1:0] i_src_b,
    output logic                                    o_in_ready,
    output msrt_pkg::t_seq_ctrl                     o_ctrl,
    output logic             [AW-1:0]               o_wr_addr,
    output logic             [AW-1:0]               o_rd_addr_a,
    output logic             [AW-1:0]               o_rd_addr_b
);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [CW-1:0] r_n,     n_n;
    logic [CW:0]   r_width, n_width;
    logic [CW-1:0] r_lo,    n_lo;
    logic [CW-1:0] r_mid,   n_mid;
    logic [CW-1:0] r_hi,    n_hi;
    logic [CW-1:0] r_i,     n_i;
    logic [CW-1:0] r_j,     n_j;
    logic [CW-1:0] r_p,     n_p;
    logic [CW-1:0] r_k,     n_k;
    logic          r_src,   n_src;

    logic [CW-1:0] cnt1;
    logic [CW+1:0] sum_mid;
    logic [CW+1:0] sum_hi;
    logic [CW-1:0] mid_c;
    logic [CW-1:0] hi_c;
    logic [CW:0]   w2;
    logic          take_left;
    logic [CW-1:0] p1;
    logic [CW-1:0] k1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_width = r_width;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_p     = r_p;
        n_k     = r_k;
        n_src   = r_src;

        o_in_ready  = 1'b0;
        o_ctrl      = '0;
        o_ctrl.rd_sel = r_src;
        o_wr_addr   = r_p[AW-1:0];
        o_rd_addr_a = r_i[AW-1:0];
        o_rd_addr_b = r_j[AW-1:0];

        cnt1      = r_cnt + CW'(1);
        sum_mid   = {2'b00, r_lo} + {1'b0, r_width};
        sum_hi    = {2'b00, r_lo} + {r_width, 1'b0};
        mid_c     = (sum_mid >= {2'b00, r_n}) ? r_n : sum_mid[CW-1:0];
        hi_c      = (sum_hi  >= {2'b00, r_n}) ? r_n : sum_hi[CW-1:0];
        w2        = {r_width[CW-1:0], 1'b0};
        // left head wins ties, which keeps equal values in arrival order
        take_left = (r_i < r_mid) && ((r_j >= r_hi) || (i_src_a <= i_src_b));
        p1        = r_p + CW'(1);
        k1        = r_k + CW'(1);

        case (r_state)
            msrt_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                o_wr_addr  = r_cnt[AW-1:0];
                if (i_in_valid) begin
                    o_ctrl.wr0_en    = 1'b1;
                    o_ctrl.wr_sel_in = 1'b1;
                    if (i_last || cnt1 == CW'(CAPACITY)) begin
                        n_n     = cnt1;
                        n_cnt   = '0;
                        n_width = (CW+1)'(1);
                        n_src   = 1'b0;
                        n_lo    = '0;
                        n_k     = '0;
                        n_state = (cnt1 == CW'(1)) ? msrt_pkg::S_OSTART
                                                   : msrt_pkg::S_MSTART;
                    end else begin
                        n_cnt = cnt1;
                    end
                end
            end
            msrt_pkg::S_MSTART: begin
                n_i         = r_lo;
                n_j         = mid_c;
                n_mid       = mid_c;
                n_hi        = hi_c;
                n_p         = r_lo;
                o_rd_addr_a = r_lo[AW-1:0];
                o_rd_addr_b = mid_c[AW-1:0];
                n_state     = msrt_pkg::S_MERGE;
            end
            msrt_pkg::S_MERGE: begin
                o_ctrl.take_left = take_left;
                o_ctrl.wr0_en    = r_src;
                o_ctrl.wr1_en    = ~r_src;
                if (take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                // fetch the next heads now so they are ready next cycle
                o_rd_addr_a = n_i[AW-1:0];
                o_rd_addr_b = n_j[AW-1:0];
                n_p = p1;
                if (p1 == r_hi) begin
                    if (r_hi == r_n) begin
                        n_width = w2;
                        n_src   = ~r_src;
                        n_lo    = '0;
                        n_k     = '0;
                        n_state = (w2 >= {1'b0, r_n}) ? msrt_pkg::S_OSTART
                                                      : msrt_pkg::S_MSTART;
                    end else begin
                        n_lo    = r_hi;
                        n_state = msrt_pkg::S_MSTART;
                    end
                end
            end
            msrt_pkg::S_OSTART: begin
                o_rd_addr_a = r_k[AW-1:0];
                n_state     = msrt_pkg::S_OLOAD;
            end
            msrt_pkg::S_OLOAD: begin
                o_ctrl.out_load = 1'b1;
                o_ctrl.out_last = (k1 == r_n);
                n_state         = msrt_pkg::S_OWAIT;
            end
            msrt_pkg::S_OWAIT: begin
                if (i_out_take) begin
                    if (k1 == r_n) begin
                        n_state = msrt_pkg::S_LOAD;
                    end else begin
                        n_k     = k1;
                        n_state = msrt_pkg::S_OSTART;
                    end
                end
            end
            default: begin
                n_state = msrt_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msrt_pkg::S_LOAD;
            r_cnt   <= '0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_p     <= n_p;
        r_k     <= n_k;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(CAPACITY))
        else $error("fill count reached capacity without closing the set");

    a_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == msrt_pkg::S_MERGE |-> r_p < r_hi)
        else $error("merge write pointer ran past its run");

    a_heads_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == msrt_pkg::S_MERGE |->
            ({1'b0, r_i} + {1'b0, r_j}) == ({1'b0, r_p} + {1'b0, r_mid}))
        else $error("merge heads do not match the number of items written");

    a_pass_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == msrt_pkg::S_MERGE |-> r_width < {1'b0, r_n})
        else $error("merge pass started with run width not below set size");

    a_out_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == msrt_pkg::S_OLOAD |-> $past(r_state) == msrt_pkg::S_OSTART)
        else $error("output load without a read issued the cycle before");

endmodule

`default_nettype wire

[hw/rtl/merge_sorter.sv]
// ----------------------------------------------------------------------------
// merge_sorter - stable bottom-up merge sort of a set of signed values
// Loads up to CAPACITY items into bank 0, merges runs back and forth
// between two banks, then emits the set in ascending order.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_ready    i_value, i_last
//  output    o_out_valid / i_out_ready  o_sorted_value, o_last_out
//
//  loading takes one item per cycle; the item with i_last, or the one that
//  fills the store, closes the set
//  sorting takes ceil(log2 n) passes, each writing every element once (one
//  element per cycle through the bank write port, with a start state per run
//  pair); results leave one at a time, the next read waiting for the take
//  no input is taken from the close of a set until its last result is taken
//  a stalled output holds its register; reset needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter #(
    parameter int CAPACITY = msrt_pkg::CAPACITY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [msrt_pkg::DATA_W-1:0] i_value,
    input  wire logic                               i_last,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [msrt_pkg::DATA_W-1:0] o_sorted_value,
    output logic                                    o_last_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    msrt_pkg::t_seq_ctrl ctrl;

    logic [AW-1:0]                      wr_addr;
    logic [AW-1:0]                      rd_addr_a;
    logic [AW-1:0]                      rd_addr_b;
    logic [msrt_pkg::DATA_W-1:0]        b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
    logic signed [msrt_pkg::DATA_W-1:0] src_a, src_b;
    logic [msrt_pkg::DATA_W-1:0]        wr_data;
    logic                               out_take;

    logic                               r_out_valid;
    logic signed [msrt_pkg::DATA_W-1:0] r_sorted_value;
    logic                               r_last_out;

    assign src_a    = ctrl.rd_sel ? b1_rd_a : b0_rd_a;
    assign src_b    = ctrl.rd_sel ? b1_rd_b : b0_rd_b;
    assign wr_data  = ctrl.wr_sel_in ? i_value : (ctrl.take_left ? src_a : src_b);
    assign out_take = r_out_valid && i_out_ready;

    msrt_ram #(.DEPTH(CAPACITY), .AW(AW)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (ctrl.wr0_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (b0_rd_a),
        .o_rdata_b (b0_rd_b)
    );

    msrt_ram #(.DEPTH(CAPACITY), .AW(AW)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (ctrl.wr1_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (b1_rd_a),
        .o_rdata_b (b1_rd_b)
    );

    msrt_seq #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .i_out_take  (out_take),
        .i_src_a     (src_a),
        .i_src_b     (src_b),
        .o_in_ready  (o_in_ready),
        .o_ctrl      (ctrl),
        .o_wr_addr   (wr_addr),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_sorted_value <= src_a;
            r_last_out     <= ctrl.out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_sorted_value;
    assign o_last_out     = r_last_out;

endmodule

`default_nettype wire
